[rtl/lattice_momentum_projection_core_defines.svh]
// ----------------------------------------------------------------------------
// Lattice momentum projection core: assertion macros
// Shared concurrent assertion forms, clocked on aclk, masked during reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_MOMENTUM_PROJECTION_CORE_DEFINES_SVH
`define LATTICE_MOMENTUM_PROJECTION_CORE_DEFINES_SVH

// Same-cycle implication
`define LMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lmp_pkg.sv]
// ----------------------------------------------------------------------------
// Lattice momentum projection package
// Lattice sizes, phase resolution, register codes, quarter-wave sine table
// and the command/status types between controller and datapath.
// ----------------------------------------------------------------------------
package lmp_pkg;

    // Lattice extents (log2) and phase resolution
    localparam int LX_LOG2    = 4;
    localparam int LY_LOG2    = 4;
    localparam int LZ_LOG2    = 4;
    localparam int LT_LOG2    = 5;
    localparam int PHASE_BITS = 10;

    localparam int QUARTER = 1 << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-2:0] QUARTER_IDX = (PHASE_BITS-1)'(QUARTER);

    localparam int ACC_W  = 50;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOM_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOM_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOM_Z = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOM_T = 2'd3;

    // pi in Q40
    localparam longint PI_Q40 = 64'sh3243F6A8886;

    typedef logic [QUARTER:0][VAL_W-1:0] qrom_t;

    typedef struct packed {
        logic signed [4:0] x;
        logic signed [4:0] y;
        logic signed [4:0] z;
        logic signed [5:0] t;
    } mom_t;

    typedef struct packed {
        logic load;      // capture item, compute phase
        logic lookup;    // read sine and cosine
        logic mult;      // form the four products
        logic accum;     // add products into the sums
        logic out_load;  // add, present the sums, clear
    } cmd_t;

    typedef struct packed {
        logic last;
    } stat_t;

    // Shift-and-subtract quotient of two non-negative values
    function automatic longint quot_pos(input longint num, input longint den);
        longint q;
        longint rem;
        int     b;
        q   = 0;
        rem = 0;
        for (b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // Build the quarter-wave table by a fixed-point Taylor series
    function automatic qrom_t build_qrom();
        qrom_t  rom;
        longint x;
        longint x2;
        longint t;
        longint sum;
        longint v;
        int     n;
        int     k;
        rom = '0;
        for (k = 0; k <= QUARTER; k++) begin
            x = (PI_Q40 * 2 * longint'(k) + (longint'(1) <<< (PHASE_BITS + 9)))
                >>> (PHASE_BITS + 10);
            x2  = (x * x) >>> 30;
            t   = x;
            sum = x;
            for (n = 1; n <= 13; n++) begin
                t = quot_pos((t * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
                if ((n % 2) == 1) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (v > 32767) begin
                v = 32767;
            end
            rom[k] = VAL_W'(v);
        end
        return rom;
    endfunction

    localparam qrom_t QROM = build_qrom();

    // Full-wave sine from the quarter table
    function automatic logic signed [VAL_W-1:0] rom_sin(input logic [PHASE_BITS-1:0] a);
        logic [1:0]              q;
        logic [PHASE_BITS-3:0]   r;
        logic [PHASE_BITS-2:0]   idx;
        logic signed [VAL_W-1:0] v;
        q   = a[PHASE_BITS-1:PHASE_BITS-2];
        r   = a[PHASE_BITS-3:0];
        idx = q[0] ? (QUARTER_IDX - {1'b0, r}) : {1'b0, r};
        v   = signed'(QROM[idx]);
        return q[1] ? -v : v;
    endfunction

endpackage

[rtl/lmp_cfg.sv]
// ----------------------------------------------------------------------------
// Momentum register file
// Holds the four signed lattice momenta written over the configuration port.
// ----------------------------------------------------------------------------
module lmp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lmp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lmp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lmp_pkg::mom_t                    mom
);

    lmp_pkg::mom_t mom_reg;
    lmp_pkg::mom_t mom_next;

    // Decode the write
    always_comb begin
        mom_next = mom_reg;
        if (cfg_we) begin
            case (cfg_addr)
                lmp_pkg::CFG_MOM_X: mom_next.x = signed'(cfg_data[4:0]);
                lmp_pkg::CFG_MOM_Y: mom_next.y = signed'(cfg_data[4:0]);
                lmp_pkg::CFG_MOM_Z: mom_next.z = signed'(cfg_data[4:0]);
                lmp_pkg::CFG_MOM_T: mom_next.t = signed'(cfg_data[5:0]);
                default:            mom_next = mom_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mom_reg <= '0;
        end else begin
            mom_reg <= mom_next;
        end
    end

    assign mom = mom_reg;

endmodule

[rtl/lmp_datapath.sv]
// ----------------------------------------------------------------------------
// Projection datapath
// Phase sum, sine/cosine lookup, complex multiply and the two accumulators,
// each step enabled by a controller command.
// ----------------------------------------------------------------------------
module lmp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lmp_pkg::cmd_t                       cmd,
    output lmp_pkg::stat_t                      stat,
    input  lmp_pkg::mom_t                       mom,
    input  logic [3:0]                          s_coord_x,
    input  logic [3:0]                          s_coord_y,
    input  logic [3:0]                          s_coord_z,
    input  logic [4:0]                          s_coord_t,
    input  logic signed [lmp_pkg::VAL_W-1:0]    s_val_re,
    input  logic signed [lmp_pkg::VAL_W-1:0]    s_val_im,
    input  logic                                s_last_site,
    output logic signed [lmp_pkg::ACC_W-1:0]    m_sum_re,
    output logic signed [lmp_pkg::ACC_W-1:0]    m_sum_im
);

    localparam int PB = lmp_pkg::PHASE_BITS;

    logic [PB-1:0] prod_x, prod_y, prod_z, prod_t;
    logic [PB-1:0] phase_next;

    logic [PB-1:0]                     phase_reg;
    logic signed [lmp_pkg::VAL_W-1:0]  vre_reg, vim_reg;
    logic                              last_reg;
    logic signed [lmp_pkg::VAL_W-1:0]  sin_reg, cos_reg;
    logic signed [lmp_pkg::PROD_W-1:0] p_cr_reg, p_si_reg, p_ci_reg, p_sr_reg;
    logic signed [lmp_pkg::ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [lmp_pkg::ACC_W-1:0]  sum_re_reg, sum_im_reg;
    logic signed [lmp_pkg::ACC_W-1:0]  acc_re_next, acc_im_next;

    // Phase in turns: each product kept to the phase width, scaled by lattice size
    always_comb begin
        prod_x = PB'(mom.x) * PB'(s_coord_x);
        prod_y = PB'(mom.y) * PB'(s_coord_y);
        prod_z = PB'(mom.z) * PB'(s_coord_z);
        prod_t = PB'(mom.t) * PB'(s_coord_t);
        phase_next = (prod_x << (PB - lmp_pkg::LX_LOG2))
                   + (prod_y << (PB - lmp_pkg::LY_LOG2))
                   + (prod_z << (PB - lmp_pkg::LZ_LOG2))
                   + (prod_t << (PB - lmp_pkg::LT_LOG2));
    end

    // Capture the item with its phase
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            phase_reg <= phase_next;
            vre_reg   <= s_val_re;
            vim_reg   <= s_val_im;
            last_reg  <= s_last_site;
        end
    end

    // Look up sine and cosine (cosine is a quarter turn ahead)
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            sin_reg <= lmp_pkg::rom_sin(phase_reg);
            cos_reg <= lmp_pkg::rom_sin(phase_reg + PB'(lmp_pkg::QUARTER));
        end
    end

    // Form the four partial products
    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            p_cr_reg <= lmp_pkg::PROD_W'(cos_reg) * lmp_pkg::PROD_W'(vre_reg);
            p_si_reg <= lmp_pkg::PROD_W'(sin_reg) * lmp_pkg::PROD_W'(vim_reg);
            p_ci_reg <= lmp_pkg::PROD_W'(cos_reg) * lmp_pkg::PROD_W'(vim_reg);
            p_sr_reg <= lmp_pkg::PROD_W'(sin_reg) * lmp_pkg::PROD_W'(vre_reg);
        end
    end

    // Running sums including the current item
    always_comb begin
        acc_re_next = acc_re_reg + lmp_pkg::ACC_W'(p_cr_reg) + lmp_pkg::ACC_W'(p_si_reg);
        acc_im_next = acc_im_reg + lmp_pkg::ACC_W'(p_ci_reg) - lmp_pkg::ACC_W'(p_sr_reg);
    end

    // Accumulate; on the last site present the sums and clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (cmd.out_load) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (cmd.accum) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sum_re_reg <= acc_re_next;
            sum_im_reg <= acc_im_next;
        end
    end

    assign stat.last = last_reg;
    assign m_sum_re  = sum_re_reg;
    assign m_sum_im  = sum_im_reg;

endmodule

[rtl/lmp_ctrl.sv]
// ----------------------------------------------------------------------------
// Projection controller
// Steps one item through capture, lookup, multiply and accumulate, and owns
// the result valid flag.
// ----------------------------------------------------------------------------
`include "lattice_momentum_projection_core_defines.svh"

module lmp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  lmp_pkg::stat_t   stat,
    output lmp_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_MULT   = 2'd2;
    localparam logic [1:0] ST_ACCUM  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The result register can take a new sum once empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequence the steps
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (!stat.last) begin
                    cmd.accum  = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    `LMP_ASSERT_NEXT(a_accept_starts, s_valid && s_ready, state_reg == ST_LOOKUP, "accepted item did not start lookup")
    `LMP_ASSERT_NEXT(a_lookup_to_mult, state_reg == ST_LOOKUP, state_reg == ST_MULT, "lookup not followed by multiply")
    `LMP_ASSERT_NOW(a_out_only_last, cmd.out_load, stat.last && !cmd.accum, "result loaded for a non-last item")
    `LMP_ASSERT_NEXT(a_blocked_waits, (state_reg == ST_ACCUM) && stat.last && !out_free, (state_reg == ST_ACCUM) && m_valid, "last item left while result register was full")

endmodule

[rtl/lattice_momentum_projection_core.sv]
// ----------------------------------------------------------------------------
// Lattice momentum projection core
// Projects a stream of lattice sites onto one momentum: each complex value
// is rotated by exp(-i 2pi p.x / L) and summed; the sums leave on the last
// site of the stream.
//
//   channel   direction   ports                               accepted when
//   s_        in          coord_x/y/z/t, val_re/im, last_site  s_valid & s_ready
//   m_        out         sum_re, sum_im                        m_valid & m_ready
//   cfg_      in          addr (momentum index), data          cfg_valid & cfg_ready
//
// Each item passes through capture with phase sum, table lookup, multiply and
// accumulate; the controller steps one item at a time through these.
// Reset (aresetn low, synchronous) clears the momenta and the running sums.
// A result waits in its output register; the next item is taken meanwhile,
// and only a later last site stalls in the accumulate step until it drains.
// ----------------------------------------------------------------------------
module lattice_momentum_projection_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [3:0]                          s_coord_x,
    input  logic [3:0]                          s_coord_y,
    input  logic [3:0]                          s_coord_z,
    input  logic [4:0]                          s_coord_t,
    input  logic signed [lmp_pkg::VAL_W-1:0]    s_val_re,
    input  logic signed [lmp_pkg::VAL_W-1:0]    s_val_im,
    input  logic                                s_last_site,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lmp_pkg::ACC_W-1:0]    m_sum_re,
    output logic signed [lmp_pkg::ACC_W-1:0]    m_sum_im,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lmp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lmp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    lmp_pkg::mom_t  mom;
    lmp_pkg::cmd_t  cmd;
    lmp_pkg::stat_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    lmp_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .mom      (mom)
    );

    lmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lmp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .mom         (mom),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .s_coord_t   (s_coord_t),
        .s_val_re    (s_val_re),
        .s_val_im    (s_val_im),
        .s_last_site (s_last_site),
        .m_sum_re    (m_sum_re),
        .m_sum_im    (m_sum_im)
    );

endmodule
